// File: rtl/core/tsa_pkg.sv
// Shared types and constants for the timing statistics accumulator.
`default_nettype none

package tsa_pkg;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned STEP_W  = $clog2(TIME_W);

    typedef enum logic [0:0] {
        OP_ACCUMULATE  = 1'b0,
        OP_READ_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PER_WAIT,
        ST_UPDATE,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_per;
        logic div_mean;
        logic update;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_nonzero;
        logic count_zero;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/tsa_divider.sv
// Restoring radix-2 divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
`default_nettype none

module tsa_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tsa_pkg::TIME_W-1:0] dividend,
    input  wire logic [tsa_pkg::CNT_W-1:0]  divisor,
    output logic                            done,
    output logic [tsa_pkg::TIME_W-1:0]      quotient
);
    import tsa_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W:0]      shifted;
    logic [CNT_W:0]      diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[TIME_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so the shifted value fits 33 bits.
            if (!diff[CNT_W])
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/tsa_datapath.sv
// Statistics registers, input and output holding registers and the shared divider.
`default_nettype none

module tsa_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tsa_pkg::cmd_t              cmd,
    output tsa_pkg::status_t                status,
    input  wire logic                       opcode,
    input  wire logic [tsa_pkg::CNT_W-1:0]  sample_count,
    input  wire logic [tsa_pkg::TIME_W-1:0] sample_total,
    output logic [tsa_pkg::CNT_W-1:0]       total_count,
    output logic [tsa_pkg::TIME_W-1:0]      total_sum,
    output logic [tsa_pkg::TIME_W-1:0]      min_time,
    output logic [tsa_pkg::TIME_W-1:0]      max_time,
    output logic [tsa_pkg::TIME_W-1:0]      mean_time
);
    import tsa_pkg::*;

    op_t               op_reg;
    logic [CNT_W-1:0]  cnt_in_reg;
    logic [TIME_W-1:0] total_in_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] sum_reg, sum_next;
    logic [TIME_W-1:0] min_reg, min_next;
    logic [TIME_W-1:0] max_reg, max_next;

    logic [CNT_W-1:0]  out_count_reg;
    logic [TIME_W-1:0] out_sum_reg;
    logic [TIME_W-1:0] out_min_reg;
    logic [TIME_W-1:0] out_max_reg;
    logic [TIME_W-1:0] out_mean_reg;

    logic              div_start;
    logic [TIME_W-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [TIME_W-1:0] div_quotient;

    assign div_start    = cmd.div_per | cmd.div_mean;
    assign div_dividend = cmd.div_per ? total_in_reg : sum_reg;
    assign div_divisor  = cmd.div_per ? cnt_in_reg : count_reg;

    tsa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op_t'(opcode);
            cnt_in_reg   <= sample_count;
            total_in_reg <= sample_total;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (cmd.update)
        begin
            // An empty store takes the per-sample time as both bounds.
            if (count_reg == '0)
            begin
                min_next = div_quotient;
                max_next = div_quotient;
            end
            else
            begin
                if (div_quotient < min_reg)
                    min_next = div_quotient;
                if (div_quotient > max_reg)
                    max_next = div_quotient;
            end
            count_next = count_reg + cnt_in_reg;
            sum_next   = sum_reg + total_in_reg;
        end
        else if (cmd.emit && op_reg == OP_READ_CLEAR)
        begin
            count_next = '0;
            sum_next   = '0;
            min_next   = '0;
            max_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_count_reg <= count_reg;
            out_sum_reg   <= sum_reg;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_mean_reg  <= (count_reg == '0) ? '0 : div_quotient;
        end
    end

    assign status.acc_nonzero = (op_reg == OP_ACCUMULATE) && (cnt_in_reg != '0);
    assign status.count_zero  = (count_reg == '0);
    assign status.div_done    = div_done;

    assign total_count = out_count_reg;
    assign total_sum   = out_sum_reg;
    assign min_time    = out_min_reg;
    assign max_time    = out_max_reg;
    assign mean_time   = out_mean_reg;

endmodule

`default_nettype wire

// File: rtl/core/tsa_ctrl.sv
// Sequencing state machine and output word valid flag.
`default_nettype none

module tsa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output tsa_pkg::cmd_t         cmd,
    input  wire tsa_pkg::status_t status
);
    import tsa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = status.acc_nonzero ? ST_PER_WAIT : ST_MEAN;
            ST_PER_WAIT:
                if (status.div_done)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = ST_MEAN;
            ST_MEAN:
                state_next = status.count_zero ? ST_EMIT : ST_MEAN_WAIT;
            ST_MEAN_WAIT:
                if (status.div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:     cmd.div_per  = status.acc_nonzero;
            ST_PER_WAIT:  cmd.update   = 1'b0;
            ST_UPDATE:    cmd.update   = 1'b1;
            ST_MEAN:      cmd.div_mean = !status.count_zero;
            ST_MEAN_WAIT: cmd.emit     = 1'b0;
            ST_EMIT:      cmd.emit     = slot_free;
            default:      cmd          = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/timing_statistics_accumulator.sv
// An accumulate with a nonzero count runs two 64-step divisions on the one shared
// radix-2 divider, first for the per-sample time and then for the mean; any other word runs
// only the mean division, or none when the store is empty.
// One word is worked on at a time; the next word can be taken in the cycle after the
// result is loaded, even while that result waits downstream.
// Reset (asynchronous, active low) clears count, sum, minimum, maximum and all control state.
`default_nettype none

module timing_statistics_accumulator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       opcode,
    input  wire logic [tsa_pkg::CNT_W-1:0]  sample_count,
    input  wire logic [tsa_pkg::TIME_W-1:0] sample_total,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [tsa_pkg::CNT_W-1:0]       total_count,
    output logic [tsa_pkg::TIME_W-1:0]      total_sum,
    output logic [tsa_pkg::TIME_W-1:0]      min_time,
    output logic [tsa_pkg::TIME_W-1:0]      max_time,
    output logic [tsa_pkg::TIME_W-1:0]      mean_time
);
    import tsa_pkg::*;

    cmd_t    cmd;
    status_t status;

    tsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tsa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .sample_count (sample_count),
        .sample_total (sample_total),
        .total_count  (total_count),
        .total_sum    (total_sum),
        .min_time     (min_time),
        .max_time     (max_time),
        .mean_time    (mean_time)
    );

    // A word taken in is worked on before another one is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous word still in work");

    // A result never overwrites a word that is still waiting downstream.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result loaded over a stalled output word");

    // The divider only finishes while a word is in work.
    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> in_stall)
        else $error("divider finished while idle");

endmodule

`default_nettype wire
